/* design/mfhs_pkg.sv */
// Shared types and constants of the multi-frame histogram stretch block.
`default_nettype none

package mfhs_pkg;

  // Fixed widths of the stream fields and configuration data.
  localparam int PIX_W        = 8;
  localparam int CFG_DATA_W   = 20;
  localparam int CFG_IDX_W    = 2;
  localparam int THRESH_SHIFT = 7;
  localparam int LIMIT_W      = CFG_DATA_W - THRESH_SHIFT;
  localparam int OUT_DATA_W   = 9 * PIX_W;

  // Table build per bin: a load step, a divider setup step, eight quotient
  // steps and a write step.
  localparam int DIV_STEPS = PIX_W;
  localparam int TK_W      = 4;
  localparam logic [TK_W-1:0] TK_LOAD       = 4'd0;
  localparam logic [TK_W-1:0] TK_INIT       = 4'd1;
  localparam logic [TK_W-1:0] TK_STEP_FIRST = 4'd2;
  localparam logic [TK_W-1:0] TK_STEP_LAST  = 4'(DIV_STEPS + 1);
  localparam logic [TK_W-1:0] TK_WRITE      = 4'(DIV_STEPS + 2);

  typedef enum logic [1:0] {
    KIND_NEW_FRAME = 2'd0,
    KIND_COUNT     = 2'd1,
    KIND_COMPUTE   = 2'd2,
    KIND_MAP       = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_THRESHOLD = 2'd0,
    CFG_FRAME_SHIFT    = 2'd1,
    CFG_OUT_LOW        = 2'd2,
    CFG_OUT_HIGH       = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_MAP_RD,
    ST_MAP_OUT,
    ST_LO,
    ST_HI,
    ST_DRAIN,
    ST_TBL,
    ST_CMP_OUT
  } state_e;

  // Control from the sequencer to each channel datapath.
  typedef struct packed {
    logic hist_re;
    logic hist_we;
    logic hist_zero;
    logic use_px;
    logic rd_valid;
    logic rd_first;
    logic rd_last;
    logic rd_hi;
    logic srch_clr;
    logic tbl_load;
    logic tbl_init;
    logic tbl_step;
    logic tbl_we;
    logic tab_re;
  } ctl_t;

  // Configuration values as the channels use them.
  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic [2:0]         shift;
    logic [PIX_W-1:0]   out_low;
    logic [PIX_W-1:0]   out_high;
    logic [PIX_W-1:0]   span;
  } cfg_t;

endpackage

`default_nettype wire

/* design/mfhs_ram.sv */
// Generic single-port-write, registered-read synchronous RAM.
`default_nettype none

module mfhs_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/mfhs_chan.sv */
// One color channel: histogram memory, averaging, clip search and stretch table.
`default_nettype none

module mfhs_chan #(
  parameter int FRAMES     = 4,
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 21
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire mfhs_pkg::ctl_t                 ctl_i,
  input  wire mfhs_pkg::cfg_t                 cfg_i,
  input  wire logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] frame_i,
  input  wire logic [$clog2(BINS)-1:0]        sweep_bin_i,
  input  wire logic [$clog2(BINS)-1:0]        rd_bin_i,
  input  wire logic [$clog2(BINS)-1:0]        px_i,
  output logic      [mfhs_pkg::PIX_W-1:0]     tab_o,
  output logic      [mfhs_pkg::PIX_W-1:0]     lo_bin_o,
  output logic      [mfhs_pkg::PIX_W-1:0]     hi_bin_o
);
  import mfhs_pkg::*;

  localparam int FB     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int BB     = $clog2(BINS);
  localparam int HA_W   = FB + BB;
  localparam int AVG_W  = COUNT_BITS + FB;
  localparam int SUM_W  = AVG_W + BB;
  localparam int CMP_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {TC_LOW, TC_HIGH, TC_DIV} tcls_e;

  // Histogram memory, addressed by frame and bin.
  logic [HA_W-1:0]       hist_addr;
  logic [COUNT_BITS-1:0] hist_rdata;
  logic [COUNT_BITS-1:0] hist_wdata;

  assign hist_addr  = {frame_i, (ctl_i.use_px ? px_i : sweep_bin_i)};
  assign hist_wdata = ctl_i.hist_zero ? '0 :
                      ((hist_rdata == CMAX) ? hist_rdata : hist_rdata + 1'b1);

  mfhs_ram #(.WIDTH(COUNT_BITS), .ADDR_W(HA_W)) u_hist (
    .clk_i  (clk_i),
    .we_i   (ctl_i.hist_we),
    .waddr_i(hist_addr),
    .wdata_i(hist_wdata),
    .re_i   (ctl_i.hist_re),
    .raddr_i(hist_addr),
    .rdata_o(hist_rdata)
  );

  // Per-bin average: each frame's count shifted, summed over the frames.
  logic [AVG_W-1:0] acc_q, acc_d;
  logic [COUNT_BITS-1:0] term;

  assign term  = hist_rdata >> cfg_i.shift;
  assign acc_d = (ctl_i.rd_first ? '0 : acc_q) + AVG_W'(term);

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_valid) begin
      acc_q <= acc_d;
    end
  end

  // Search stage: one finished average per cycle at most.
  logic          sv_q;
  logic          shi_q;
  logic [AVG_W-1:0] avg_q;
  logic [BB-1:0] sbin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else begin
      sv_q <= ctl_i.rd_valid & ctl_i.rd_last;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q  <= acc_d;
    shi_q  <= ctl_i.rd_hi;
    sbin_q <= rd_bin_i;
  end

  // Cumulative clip searches from both ends.
  logic [SUM_W-1:0] lo_sum_q, hi_sum_q;
  logic [BB-1:0]    lo_q, hi_q;
  logic             lo_open, hi_open;

  assign lo_open = CMP_W'(lo_sum_q) <= CMP_W'(cfg_i.limit);
  assign hi_open = CMP_W'(hi_sum_q) <= CMP_W'(cfg_i.limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_sum_q <= '0;
      hi_sum_q <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
    end else if (ctl_i.srch_clr) begin
      lo_sum_q <= '0;
      hi_sum_q <= '0;
      lo_q     <= '0;
      hi_q     <= BB'(BINS - 1);
    end else if (sv_q) begin
      if (!shi_q && lo_open) begin
        lo_sum_q <= lo_sum_q + SUM_W'(avg_q);
        lo_q     <= sbin_q;
      end
      if (shi_q && hi_open) begin
        hi_sum_q <= hi_sum_q + SUM_W'(avg_q);
        hi_q     <= sbin_q;
      end
    end
  end

  assign lo_bin_o = PIX_W'(lo_q);
  assign hi_bin_o = PIX_W'(hi_q);

  // Stretch value per bin: product, then a restoring quotient, a bit a cycle.
  tcls_e              cls_q;
  logic [2*PIX_W-1:0] prod_q;
  logic [PIX_W-1:0]   d_q, rem_q, num_q, quo_q;
  logic [PIX_W:0]     rem_w;
  logic               ge;
  logic [PIX_W-1:0]   tval;

  assign rem_w = {rem_q, num_q[PIX_W-1]};
  assign ge    = rem_w >= {1'b0, d_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.tbl_load) begin
      if (sweep_bin_i < lo_q) begin
        cls_q <= TC_LOW;
      end else if (sweep_bin_i > hi_q || hi_q == lo_q) begin
        cls_q <= TC_HIGH;
      end else begin
        cls_q <= TC_DIV;
      end
      prod_q <= PIX_W'(sweep_bin_i - lo_q) * cfg_i.span;
      d_q    <= PIX_W'(hi_q - lo_q);
    end
    if (ctl_i.tbl_init) begin
      rem_q <= prod_q[2*PIX_W-1:PIX_W];
      num_q <= prod_q[PIX_W-1:0];
      quo_q <= '0;
    end
    if (ctl_i.tbl_step) begin
      rem_q <= ge ? PIX_W'(rem_w - {1'b0, d_q}) : rem_w[PIX_W-1:0];
      num_q <= num_q << 1;
      quo_q <= {quo_q[PIX_W-2:0], ge};
    end
  end

  always_comb begin
    case (cls_q)
      TC_LOW:  tval = cfg_i.out_low;
      TC_HIGH: tval = cfg_i.out_high;
      default: tval = quo_q;
    endcase
  end

  // Stretch table memory.
  mfhs_ram #(.WIDTH(PIX_W), .ADDR_W(BB)) u_tab (
    .clk_i  (clk_i),
    .we_i   (ctl_i.tbl_we),
    .waddr_i(sweep_bin_i),
    .wdata_i(tval),
    .re_i   (ctl_i.tab_re),
    .raddr_i(px_i),
    .rdata_o(tab_o)
  );

endmodule

`default_nettype wire

/* design/mfhs_ctrl.sv */
// Sequencer: item decode, memory sweeps, search passes and table build.
`default_nettype none

module mfhs_ctrl #(
  parameter int FRAMES = 4,
  parameter int BINS   = 256
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire mfhs_pkg::kind_e         in_kind_i,
  output logic                         in_ready_o,
  input  wire logic                    out_free_i,
  output logic                         out_load_o,
  output logic                         out_compute_o,
  output mfhs_pkg::ctl_t               ctl_o,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] frame_o,
  output logic [$clog2(BINS)-1:0]      sweep_bin_o,
  output logic [$clog2(BINS)-1:0]      rd_bin_o
);
  import mfhs_pkg::*;

  localparam int FB = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int BB = $clog2(BINS);
  localparam logic [FB-1:0] F_LAST = FB'(FRAMES - 1);
  localparam logic [BB-1:0] B_LAST = BB'(BINS - 1);

  state_e state_q, state_d;
  logic [FB-1:0]   f_q, f_d, oldest_q, oldest_d, newest;
  logic [BB-1:0]   b_q, b_d;
  logic [TK_W-1:0] tk_q, tk_d;
  logic            rd_v_q, rd_first_q, rd_last_q, rd_hi_q, srch_v_q;
  logic [BB-1:0]   rd_bin_q;
  logic            issue, issue_hi, f_last;

  assign newest = (oldest_q == '0) ? F_LAST : oldest_q - 1'b1;
  assign f_last = f_q == F_LAST;

  // State and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      f_q      <= '0;
      b_q      <= '0;
      tk_q     <= '0;
      oldest_q <= '0;
      rd_v_q   <= 1'b0;
      srch_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      f_q      <= f_d;
      b_q      <= b_d;
      tk_q     <= tk_d;
      oldest_q <= oldest_d;
      rd_v_q   <= issue;
      srch_v_q <= rd_v_q & rd_last_q;
    end
  end

  // Tags that travel with a histogram read to its data cycle.
  always_ff @(posedge clk_i) begin
    rd_first_q <= f_q == '0;
    rd_last_q  <= f_last;
    rd_hi_q    <= issue_hi;
    rd_bin_q   <= b_q;
  end

  // Next state and control.
  always_comb begin
    state_d       = state_q;
    f_d           = f_q;
    b_d           = b_q;
    tk_d          = tk_q;
    oldest_d      = oldest_q;
    frame_o       = f_q;
    in_ready_o    = 1'b0;
    out_load_o    = 1'b0;
    out_compute_o = 1'b0;
    issue         = 1'b0;
    issue_hi      = 1'b0;
    ctl_o         = '0;
    case (state_q)
      ST_INIT: begin
        ctl_o.hist_we   = 1'b1;
        ctl_o.hist_zero = 1'b1;
        {f_d, b_d}      = {f_q, b_q} + 1'b1;
        if ((&f_q) && (&b_q)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_kind_i)
            KIND_NEW_FRAME: begin
              b_d     = '0;
              state_d = ST_CLEAR;
            end
            KIND_COUNT:   state_d = ST_CNT_RD;
            KIND_COMPUTE: begin
              ctl_o.srch_clr = 1'b1;
              f_d            = '0;
              b_d            = '0;
              state_d        = ST_LO;
            end
            default:      state_d = ST_MAP_RD;
          endcase
        end
      end
      ST_CLEAR: begin
        frame_o         = oldest_q;
        ctl_o.hist_we   = 1'b1;
        ctl_o.hist_zero = 1'b1;
        b_d             = b_q + 1'b1;
        if (&b_q) begin
          oldest_d = (oldest_q == F_LAST) ? '0 : oldest_q + 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_CNT_RD: begin
        frame_o       = newest;
        ctl_o.use_px  = 1'b1;
        ctl_o.hist_re = 1'b1;
        state_d       = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        frame_o       = newest;
        ctl_o.use_px  = 1'b1;
        ctl_o.hist_we = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_MAP_RD: begin
        ctl_o.tab_re = 1'b1;
        state_d      = ST_MAP_OUT;
      end
      ST_MAP_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_LO, ST_HI: begin
        ctl_o.hist_re = 1'b1;
        issue         = 1'b1;
        issue_hi      = state_q == ST_HI;
        f_d           = f_last ? '0 : f_q + 1'b1;
        if (f_last) begin
          b_d = issue_hi ? b_q - 1'b1 : b_q + 1'b1;
        end
        if (f_last && !issue_hi && b_q == B_LAST) begin
          b_d     = B_LAST;
          state_d = ST_HI;
        end
        if (f_last && issue_hi && b_q == BB'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !srch_v_q) begin
          b_d     = '0;
          tk_d    = TK_LOAD;
          state_d = ST_TBL;
        end
      end
      ST_TBL: begin
        tk_d = tk_q + 1'b1;
        if (tk_q == TK_LOAD) begin
          ctl_o.tbl_load = 1'b1;
        end
        if (tk_q == TK_INIT) begin
          ctl_o.tbl_init = 1'b1;
        end
        if (tk_q inside {[TK_STEP_FIRST:TK_STEP_LAST]}) begin
          ctl_o.tbl_step = 1'b1;
        end
        if (tk_q == TK_WRITE) begin
          ctl_o.tbl_we = 1'b1;
          tk_d         = TK_LOAD;
          b_d          = b_q + 1'b1;
          if (b_q == B_LAST) begin
            state_d = ST_CMP_OUT;
          end
        end
      end
      ST_CMP_OUT: begin
        if (out_free_i) begin
          out_load_o    = 1'b1;
          out_compute_o = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    ctl_o.rd_valid = rd_v_q;
    ctl_o.rd_first = rd_first_q;
    ctl_o.rd_last  = rd_last_q;
    ctl_o.rd_hi    = rd_hi_q;
  end

  assign sweep_bin_o = b_q;
  assign rd_bin_o    = rd_bin_q;

endmodule

`default_nettype wire

/* design/multi_frame_histogram_stretch.sv */
// Top level: per-channel auto-levels stretch over a multi-frame histogram history.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+--------------------------------------
//  s_axis   | s_axis_tvalid/s_axis_tready  | tuser kind, tdata red/green/blue
//  m_axis   | m_axis_tvalid/m_axis_tready  | tuser from_compute, tdata pixel+bins
//  cfg      | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
//  After reset the histogram memories are swept to zero, one row a cycle,
//  over all 2^(clog2(FRAMES)+clog2(BINS)) rows (1024 at the defaults); no item is taken then.
//  Count item: a read and a write of its bin. Map item: a table read, then the result load.
//  New-frame item: a clear of every bin in the oldest frame. Compute item: a low and a high
//  search pass with one histogram read a cycle, then the table build with the bit-serial divider.
//  A result waits in the output register; a stall holds only a map or compute
//  item that needs that register.
`default_nettype none

module multi_frame_histogram_stretch #(
  parameter int FRAMES     = 4,
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 21
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [23:0]                       s_axis_tdata,  // red_in, green_in, blue_in
  input  wire logic [1:0]                        s_axis_tuser,  // kind
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // red_out, green_out, blue_out, red_low_bin, red_high_bin, green_low_bin,
  // green_high_bin, blue_low_bin, blue_high_bin
  output logic [mfhs_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tuser,  // from_compute
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mfhs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mfhs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mfhs_pkg::*;

  localparam int FB = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int BB = $clog2(BINS);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] clip_threshold_q;
  logic [2:0]            frame_shift_q;
  logic [PIX_W-1:0]      out_low_q, out_high_q;
  cfg_t                  cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_threshold_q <= CFG_DATA_W'(8192);
      frame_shift_q    <= 3'd2;
      out_low_q        <= '0;
      out_high_q       <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CLIP_THRESHOLD: clip_threshold_q <= cfg_data_i;
        CFG_FRAME_SHIFT:    frame_shift_q    <= cfg_data_i[2:0];
        CFG_OUT_LOW:        out_low_q        <= cfg_data_i[PIX_W-1:0];
        CFG_OUT_HIGH:       out_high_q       <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.limit    = clip_threshold_q[CFG_DATA_W-1:THRESH_SHIFT];
  assign cfg.shift    = frame_shift_q;
  assign cfg.out_low  = out_low_q;
  assign cfg.out_high = out_high_q;
  assign cfg.span     = (out_high_q >= out_low_q) ? out_high_q - out_low_q : '0;

  // Sequencer.
  ctl_t          ctl;
  logic [FB-1:0] frame;
  logic [BB-1:0] sweep_bin, rd_bin;
  logic          out_free, out_load, out_compute, in_acc;

  assign in_acc = s_axis_tvalid & s_axis_tready;

  mfhs_ctrl #(.FRAMES(FRAMES), .BINS(BINS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_kind_i    (kind_e'(s_axis_tuser)),
    .in_ready_o   (s_axis_tready),
    .out_free_i   (out_free),
    .out_load_o   (out_load),
    .out_compute_o(out_compute),
    .ctl_o        (ctl),
    .frame_o      (frame),
    .sweep_bin_o  (sweep_bin),
    .rd_bin_o     (rd_bin)
  );

  // Channels; a pixel component beyond the last bin lands in the last bin.
  logic [PIX_W-1:0] tab [3];
  logic [PIX_W-1:0] lo_bin [3];
  logic [PIX_W-1:0] hi_bin [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [PIX_W-1:0] comp;
    logic [BB-1:0]    px_q;

    assign comp = s_axis_tdata[PIX_W*c +: PIX_W];

    always_ff @(posedge clk_i) begin
      if (in_acc) begin
        px_q <= ((PIX_W + 1)'(comp) >= (PIX_W + 1)'(BINS)) ? BB'(BINS - 1) : BB'(comp);
      end
    end

    mfhs_chan #(.FRAMES(FRAMES), .BINS(BINS), .COUNT_BITS(COUNT_BITS)) u_chan (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .cfg_i      (cfg),
      .frame_i    (frame),
      .sweep_bin_i(sweep_bin),
      .rd_bin_i   (rd_bin),
      .px_i       (px_q),
      .tab_o      (tab[c]),
      .lo_bin_o   (lo_bin[c]),
      .hi_bin_o   (hi_bin[c])
    );
  end

  // Output register.
  logic                  out_v_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_user_q;

  assign out_free = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_user_q <= out_compute;
      out_data_q <= {hi_bin[2], lo_bin[2], hi_bin[1], lo_bin[1], hi_bin[0], lo_bin[0],
                     (out_compute ? 24'd0 : {tab[2], tab[1], tab[0]})};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

/* design/mfhs_checker.sv */
// Port-level checks on the histogram stretch block, bound to the top level.
`default_nettype none

module mfhs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  import mfhs_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid & s_axis_tready;

  // A stalled result holds its valid and payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // New-frame and count items never raise a result in the next cycle.
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !m_axis_tvalid &&
    (s_axis_tuser == KIND_NEW_FRAME || s_axis_tuser == KIND_COUNT) |=> !m_axis_tvalid)
    else $error("result appeared for an item without one");

  // A compute item keeps the input closed while the table is built.
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser == KIND_COMPUTE |=> !s_axis_tready)
    else $error("input reopened during compute");

  // A compute result carries a zero pixel.
  a_compute_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:0] == 24'd0)
    else $error("compute result with nonzero pixel");

endmodule

bind multi_frame_histogram_stretch mfhs_checker u_mfhs_checker (.*);

`default_nettype wire

/* dv/mfhs_checker.sv */
// Checker for the multi-frame histogram stretch: watches the channels, predicts and compares.
`timescale 1ns / 100ps

module mfhs_scoreboard (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  input  wire logic [23:0]                     s_axis_tdata,
  input  wire logic [1:0]                      s_axis_tuser,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic [mfhs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                            m_axis_tuser,
  input  wire logic                            cfg_valid_i,
  input  wire logic                            cfg_ready_o,
  input  wire logic [mfhs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mfhs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  import mfhs_pkg::*;

  localparam int NFRAMES = 4;
  localparam int NBINS   = 256;
  localparam int CNT_W   = 21;

  typedef struct packed {
    logic                  from_compute;
    logic [OUT_DATA_W-1:0] payload;
  } levels_result_t;

  // Predicted state of the block.
  logic [CNT_W-1:0]      hist_mem [NFRAMES][NBINS][3];
  logic [1:0]            oldest_slot;
  logic [PIX_W-1:0]      stretch_lut [NBINS][3];
  logic [PIX_W-1:0]      clip_bin [6];
  logic [CFG_DATA_W-1:0] thr_reg;
  logic [2:0]            shift_reg;
  logic [PIX_W-1:0]      low_reg;
  logic [PIX_W-1:0]      high_reg;

  levels_result_t levels_q[$];

  string field_name [9] = '{"red_out", "green_out", "blue_out", "red_low_bin", "red_high_bin",
                            "green_low_bin", "green_high_bin", "blue_low_bin", "blue_high_bin"};

  // Return the model to its state after reset.
  task automatic clear_model();
    for (int f = 0; f < NFRAMES; f++)
      for (int i = 0; i < NBINS; i++)
        for (int c = 0; c < 3; c++) hist_mem[f][i][c] = '0;
    foreach (clip_bin[k]) clip_bin[k] = '0;
    oldest_slot = '0;
    thr_reg     = 20'd8192;
    shift_reg   = 3'd2;
    low_reg     = 8'd0;
    high_reg    = 8'd255;
  endtask

  // Average the history, find the clip bins and rebuild the stretch table.
  task automatic build_stretch();
    longint unsigned avg [NBINS][3];
    longint unsigned acc;
    longint unsigned lim;
    int unsigned     span, lo, hi, v;
    lim  = thr_reg >> THRESH_SHIFT;
    span = (high_reg >= low_reg) ? high_reg - low_reg : 0;
    for (int i = 0; i < NBINS; i++)
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int f = 0; f < NFRAMES; f++) acc += hist_mem[f][i][c] >> shift_reg;
        avg[i][c] = acc;
      end
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      lo  = 0;
      hi  = NBINS - 1;
      for (int i = 0; i < NBINS; i++)
        if (acc <= lim) begin
          acc += avg[i][c];
          lo = i;
        end
      acc = 0;
      for (int i = NBINS - 1; i > 0; i--)
        if (acc <= lim) begin
          acc += avg[i][c];
          hi = i;
        end
      clip_bin[2*c]   = lo[7:0];
      clip_bin[2*c+1] = hi[7:0];
      for (int unsigned u = 0; u < NBINS; u++) begin
        if (u < lo) v = low_reg;
        else if (u > hi) v = high_reg;
        else if (hi == lo) v = high_reg;
        else v = (u - lo) * span / (hi - lo);
        stretch_lut[u][c] = v[7:0];
      end
    end
  endtask

  // Apply one accepted input item and queue the result it causes.
  task automatic predict_item(input kind_e kind, input logic [23:0] pix);
    levels_result_t r;
    logic [1:0]     newest;
    logic [7:0]     comp;
    newest = oldest_slot - 2'd1;
    r      = '0;
    case (kind)
      KIND_NEW_FRAME: begin
        for (int i = 0; i < NBINS; i++)
          for (int c = 0; c < 3; c++) hist_mem[oldest_slot][i][c] = '0;
        oldest_slot = oldest_slot + 2'd1;
      end
      KIND_COUNT: begin
        for (int c = 0; c < 3; c++) begin
          comp = pix[8*c +: 8];
          if (hist_mem[newest][comp][c] != '1)
            hist_mem[newest][comp][c] = hist_mem[newest][comp][c] + 1'b1;
        end
      end
      KIND_COMPUTE: begin
        build_stretch();
        r.from_compute = 1'b1;
      end
      default: begin
        for (int c = 0; c < 3; c++) r.payload[8*c +: 8] = stretch_lut[pix[8*c +: 8]][c];
      end
    endcase
    if (kind == KIND_COMPUTE || kind == KIND_MAP) begin
      for (int k = 0; k < 6; k++) r.payload[24 + 8*k +: 8] = clip_bin[k];
      levels_q.push_back(r);
    end
  endtask

  // Compare one result with the oldest expectation.
  task automatic check_result();
    levels_result_t exp_r;
    bit             bad;
    if (levels_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: unexpected result tuser=%0b tdata=%h", $realtime, m_axis_tuser,
                 m_axis_tdata);
      return;
    end
    exp_r = levels_q.pop_front();
    bad   = 1'b0;
    if (m_axis_tuser !== exp_r.from_compute) begin
      bad = 1'b1;
      if (fail_count_o < 10)
        $display("%0t: from_compute expected %0b got %0b", $realtime, exp_r.from_compute,
                 m_axis_tuser);
    end
    for (int k = 0; k < 9; k++)
      if (m_axis_tdata[8*k +: 8] !== exp_r.payload[8*k +: 8]) begin
        if (fail_count_o < 10 && !bad)
          $display("%0t: %s expected %0d got %0d", $realtime, field_name[k],
                   exp_r.payload[8*k +: 8], m_axis_tdata[8*k +: 8]);
        bad = 1'b1;
      end
    if (bad) fail_count_o++;
  endtask

  // Sample all channels at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      levels_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CLIP_THRESHOLD: thr_reg   = cfg_data_i;
          CFG_FRAME_SHIFT:    shift_reg = cfg_data_i[2:0];
          CFG_OUT_LOW:        low_reg   = cfg_data_i[7:0];
          default:            high_reg  = cfg_data_i[7:0];
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) predict_item(kind_e'(s_axis_tuser), s_axis_tdata);
    end
    pending_o = levels_q.size();
  end

endmodule

/* dv/tb_multi_frame_histogram_stretch.sv */
// Testbench top for the multi-frame histogram stretch: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module tb_multi_frame_histogram_stretch;
  import mfhs_pkg::*;

  localparam int  ITEM_TARGET = 1400;
  localparam int  SETTLE_CYC  = 300;
  localparam longint CYCLE_LIMIT = 3000000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    fail_count;
  int                    pending;

  // Shared stimulus controls.
  bit     quiet;
  bit     hold_req;
  bit     table_built;
  int     items_sent;
  longint cycle_cnt;
  logic [7:0] center [3];
  int     spread;

  multi_frame_histogram_stretch dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  mfhs_scoreboard u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, long hold-offs on request.
  always @(posedge clk_i) begin
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (400) @(posedge clk_i);
      hold_req <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 37);
    end
  end

  // Offer one input item, optionally after an idle gap; called and returns at a clock edge.
  task automatic push_item(input kind_e kind, input logic [7:0] r, g, b);
    if (!quiet && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {b, g, r};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
    if (kind == KIND_COMPUTE) table_built = 1'b1;
  endtask

  // Wait for every expected result and for the block to go quiet.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || !s_axis_tready) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Write all four registers while idle.
  task automatic set_levels(input logic [19:0] thr, input logic [2:0] sh,
                            input logic [7:0] lo, input logic [7:0] hi);
    drain_block();
    write_reg(CFG_CLIP_THRESHOLD, thr);
    write_reg(CFG_FRAME_SHIFT, {17'd0, sh});
    write_reg(CFG_OUT_LOW, {12'd0, lo});
    write_reg(CFG_OUT_HIGH, {12'd0, hi});
    cfg_valid_i <= 1'b0;
  endtask

  // Pixel value near the channel centers, or fully random now and then.
  function automatic logic [7:0] pick_comp(input int c);
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return center[c] + 8'($urandom_range(0, spread));
  endfunction

  // Counted or mapped pixel: any value, or one near the histogram centers.
  task automatic push_pixel(input kind_e kind);
    push_item(kind, pick_comp(0), pick_comp(1), pick_comp(2));
  endtask

  initial begin
    int n_cnt, n_map, round;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_NEW_FRAME;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_CLIP_THRESHOLD;
    cfg_data_i    = '0;
    quiet = 1'b0; hold_req = 1'b0; table_built = 1'b0;
    items_sent = 0; cycle_cnt = 0; spread = 7;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-history compute gives crossed bins, then extreme pixels.
    push_item(KIND_COMPUTE, 8'h00, 8'h00, 8'h00);
    push_item(KIND_MAP, 8'h00, 8'hFF, 8'h80);
    push_item(KIND_MAP, 8'hFF, 8'h00, 8'h7F);
    push_item(KIND_COUNT, 8'h00, 8'hFF, 8'hAA);
    push_item(KIND_COUNT, 8'hFF, 8'h00, 8'h55);
    push_item(KIND_NEW_FRAME, 8'hFF, 8'hFF, 8'hFF);
    push_item(KIND_COUNT, 8'h55, 8'hAA, 8'h00);
    push_item(KIND_COMPUTE, 8'hFF, 8'hFF, 8'hFF);
    push_item(KIND_MAP, 8'hAA, 8'h55, 8'hFF);
    // Equal clip bins: one populated bin and a zero limit.
    set_levels(20'd0, 3'd0, 8'd0, 8'd255);
    repeat (4) push_item(KIND_NEW_FRAME, 8'd0, 8'd0, 8'd0);
    repeat (3) push_item(KIND_COUNT, 8'd100, 8'd100, 8'd100);
    push_item(KIND_COMPUTE, 8'd0, 8'd0, 8'd0);
    push_item(KIND_MAP, 8'd99, 8'd100, 8'd101);
    // Inverted outputs at the register extremes.
    set_levels(20'hFFFFF, 3'd7, 8'd255, 8'd0);
    push_item(KIND_COMPUTE, 8'd0, 8'd0, 8'd0);
    push_item(KIND_MAP, 8'd100, 8'd0, 8'd255);
    set_levels(20'd640, 3'd0, 8'd20, 8'd200);
    push_item(KIND_COMPUTE, 8'd0, 8'd0, 8'd0);
    push_item(KIND_MAP, 8'd100, 8'd50, 8'd150);

    // Random rounds: new frame, pixel counts, compute, mapped pixels.
    round = 0;
    while (items_sent < ITEM_TARGET) begin
      round++;
      quiet = (round >= 4 && round <= 6);
      if (round % 5 == 0) begin
        case ($urandom_range(0, 3))
          0: set_levels(20'd0, 3'd0, 8'd0, 8'd255);
          1: set_levels(20'hFFFFF, 3'd7, 8'd255, 8'd255);
          default: set_levels(20'(($urandom_range(0, 40) << 7) | $urandom_range(0, 127)),
                              3'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        endcase
      end
      for (int c = 0; c < 3; c++) center[c] = 8'($urandom);
      spread = $urandom_range(0, 15);
      push_item(KIND_NEW_FRAME, 8'($urandom), 8'($urandom), 8'($urandom));
      n_cnt = $urandom_range(10, 60);
      repeat (n_cnt) push_pixel(KIND_COUNT);
      if ($urandom_range(0, 2) != 0 || !table_built) push_item(KIND_COMPUTE, 8'($urandom),
                                                           8'($urandom), 8'($urandom));
      if (round % 4 == 2) begin
        hold_req = 1'b1;
      end
      n_map = $urandom_range(10, 40);
      repeat (n_map) push_pixel(KIND_MAP);
      // Noise: any kind in any order.
      repeat ($urandom_range(0, 4)) begin
        kind_e k;
        k = kind_e'($urandom_range(0, 3));
        if (k == KIND_COMPUTE && $urandom_range(0, 3) != 0) k = KIND_COUNT;
        push_item(k, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      if (round % 3 == 0) drain_block();
    end
    quiet = 1'b0;
    drain_block();

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
design/mfhs_pkg.sv
design/mfhs_ram.sv
design/mfhs_chan.sv
design/mfhs_ctrl.sv
design/multi_frame_histogram_stretch.sv
design/mfhs_checker.sv
dv/mfhs_checker.sv
dv/tb_multi_frame_histogram_stretch.sv
